>>> hdl/csvt_pkg.sv
// Package for the CSV field tokenizer: parser mode codes, register indexes,
// counter sizing and the structs passed between the top level and the step logic.
// No dependencies.
package csvt_pkg;

  localparam int unsigned MaxFields = 256;
  localparam int unsigned CntW      = $clog2(MaxFields);

  localparam logic [7:0] QuoteChar = 8'h22;
  localparam logic [7:0] CrChar    = 8'h0D;
  localparam logic [7:0] LfChar    = 8'h0A;
  localparam logic [7:0] SpaceChar = 8'h20;
  localparam logic [7:0] TabChar   = 8'h09;

  localparam logic [7:0] FieldDelimReset   = 8'd44;
  localparam logic [7:0] CommentDelimReset = 8'd0;

  // configuration register indexes
  localparam logic [7:0] RegFieldDelim   = 8'd0;
  localparam logic [7:0] RegCommentDelim = 8'd1;

  // parser modes
  localparam logic [2:0] ModeLineBegin  = 3'd0;
  localparam logic [2:0] ModeFieldStart = 3'd1;
  localparam logic [2:0] ModeUnquoted   = 3'd2;
  localparam logic [2:0] ModeQuoted     = 3'd3;
  localparam logic [2:0] ModeQuoteSeen  = 3'd4;
  localparam logic [2:0] ModeAfterQuote = 3'd5;
  localparam logic [2:0] ModeComment    = 3'd6;

  typedef struct packed {
    logic [2:0]      mode;
    logic [CntW-1:0] cnt;
    logic            prev_cr;
    logic            err;
  } parse_state_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic       field_end;
    logic       record_end;
    logic [7:0] field_index;
    logic       parse_error;
  } token_t;

endpackage

>>> hdl/csvt_step.sv
// Combinational step logic of the CSV field tokenizer: takes one byte and the
// current parser state, gives the next state and the token for that byte.
// Depends on csvt_pkg.
module csvt_step (
  input  csvt_pkg::parse_state_t state_i,
  input  logic [7:0]             byte_i,
  input  logic                   eoi_i,
  input  logic [7:0]             field_delim_i,
  input  logic [7:0]             comment_delim_i,
  output csvt_pkg::parse_state_t state_o,
  output csvt_pkg::token_t       token_o
);

  logic is_delim, is_comment, is_quote, is_blank, is_line_end;
  logic bump;
  logic [csvt_pkg::CntW-1:0] cnt_bumped;

  assign is_delim   = (byte_i == field_delim_i);
  assign is_comment = (comment_delim_i != 8'd0) && (byte_i == comment_delim_i);
  assign is_quote   = (byte_i == csvt_pkg::QuoteChar);
  assign is_blank   = (byte_i == csvt_pkg::SpaceChar) || (byte_i == csvt_pkg::TabChar);
  assign is_line_end = eoi_i ||
                       (((byte_i == csvt_pkg::CrChar) || (byte_i == csvt_pkg::LfChar)) &&
                        (state_i.mode != csvt_pkg::ModeQuoted));

  assign cnt_bumped = (state_i.cnt < csvt_pkg::CntW'(csvt_pkg::MaxFields - 1)) ?
                      state_i.cnt + 1'b1 : state_i.cnt;

  always_comb begin
    state_o             = state_i;
    state_o.prev_cr     = 1'b0;
    token_o.data_valid  = 1'b0;
    token_o.data_byte   = 8'd0;
    token_o.field_end   = 1'b0;
    token_o.record_end  = 1'b0;
    token_o.field_index = 8'(state_i.cnt);
    bump                = 1'b0;

    if (is_line_end) begin
      // drop the LF of a CRLF pair
      if (!(!eoi_i && byte_i == csvt_pkg::LfChar && state_i.prev_cr)) begin
        state_o.prev_cr = !eoi_i && (byte_i == csvt_pkg::CrChar);
        unique case (state_i.mode)
          csvt_pkg::ModeLineBegin: ;
          csvt_pkg::ModeFieldStart, csvt_pkg::ModeComment: begin
            token_o.record_end = 1'b1;
          end
          default: begin
            token_o.field_end  = 1'b1;
            token_o.record_end = 1'b1;
          end
        endcase
        state_o.mode = csvt_pkg::ModeLineBegin;
        state_o.cnt  = '0;
      end
    end else begin
      unique case (state_i.mode)
        csvt_pkg::ModeLineBegin, csvt_pkg::ModeFieldStart, csvt_pkg::ModeUnquoted: begin
          if (is_delim) begin
            bump         = 1'b1;
            state_o.mode = csvt_pkg::ModeFieldStart;
          end else if (is_comment) begin
            bump         = 1'b1;
            state_o.mode = csvt_pkg::ModeComment;
          end else if (is_quote) begin
            state_o.mode = csvt_pkg::ModeQuoted;
          end else begin
            token_o.data_valid = 1'b1;
            token_o.data_byte  = byte_i;
            state_o.mode       = csvt_pkg::ModeUnquoted;
          end
        end
        csvt_pkg::ModeQuoted: begin
          if (is_quote) begin
            state_o.mode = csvt_pkg::ModeQuoteSeen;
          end else begin
            token_o.data_valid = 1'b1;
            token_o.data_byte  = byte_i;
          end
        end
        csvt_pkg::ModeQuoteSeen, csvt_pkg::ModeAfterQuote: begin
          if (state_i.mode == csvt_pkg::ModeQuoteSeen && is_quote) begin
            // doubled quote: one literal quote
            token_o.data_valid = 1'b1;
            token_o.data_byte  = csvt_pkg::QuoteChar;
            state_o.mode       = csvt_pkg::ModeQuoted;
          end else if (is_blank) begin
            state_o.mode = csvt_pkg::ModeAfterQuote;
          end else if (is_delim) begin
            bump         = 1'b1;
            state_o.mode = csvt_pkg::ModeFieldStart;
          end else if (is_comment) begin
            bump         = 1'b1;
            state_o.mode = csvt_pkg::ModeComment;
          end else begin
            // stray byte after a closing quote: flag it, drop the rest of the line
            state_o.err  = 1'b1;
            bump         = 1'b1;
            state_o.mode = csvt_pkg::ModeComment;
          end
        end
        default: ;
      endcase
      if (bump) begin
        token_o.field_end = 1'b1;
        state_o.cnt       = cnt_bumped;
      end
    end

    token_o.parse_error = state_o.err;
  end

endmodule

>>> hdl/csv_field_tokenizer_unit.sv
// Top level of the CSV field tokenizer: input register, parser state, result
// register and the configuration registers.
// Depends on csvt_pkg and csvt_step.
//
// Usage:
//   Feed CSV text on the s_axis channel, one byte per word in tdata; raise
//   tlast on a word to mark end of text (its byte is ignored, it closes the
//   current line). Every input word gives exactly one output word on m_axis:
//   tdata carries the field content byte and the field index, tuser flags
//   data valid, field end and the sticky parse error, tlast marks the end of
//   a record. Field and comment delimiters are set over the cfg channel
//   (index 0 field delimiter, index 1 comment character, 0 = no comments);
//   write them only while no word is in flight.
// Timing:
//   Throughput is one word per cycle while m_axis_tready is high. An accepted
//   word sits in the input register, runs through the parse step and is
//   loaded into the result register that drives its token on m_axis. The parser
//   state lives in registers updated in the same cycle the result is loaded.
// Reset and stall:
//   rst_ni clears both pipeline stages, the parser state (line begin, field
//   count zero, error clear) and restores the delimiters to comma / none.
//   When m_axis_tready is low the result register holds and the input
//   register fills, then s_axis_tready drops; no word is lost or repeated.
module csv_field_tokenizer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input text
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic        s_axis_tlast_i,   // end_of_input
  // tokens
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] data_byte, [15:8] field_index
  output logic [2:0]  m_axis_tuser_o,   // [0] data_valid, [1] field_end, [2] parse_error
  output logic        m_axis_tlast_o,   // record_end
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_addr_i,
  input  logic [7:0]  cfg_data_i
);

  logic [7:0] field_delim_q, comment_delim_q;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_eoi_q;

  logic             out_valid_q;
  csvt_pkg::token_t out_tok_q;

  csvt_pkg::parse_state_t state_q, state_d;
  csvt_pkg::token_t       tok_d;

  logic out_free, advance;

  // Config port: always ready, writes land the same edge.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_delim_q   <= csvt_pkg::FieldDelimReset;
      comment_delim_q <= csvt_pkg::CommentDelimReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        csvt_pkg::RegFieldDelim:   field_delim_q   <= cfg_data_i;
        csvt_pkg::RegCommentDelim: comment_delim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance the input word into the result stage when the result register
  // is empty or being drained this cycle.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_eoi_q  <= s_axis_tlast_i;
    end
  end

  csvt_step u_step (
    .state_i         (state_q),
    .byte_i          (in_byte_q),
    .eoi_i           (in_eoi_q),
    .field_delim_i   (field_delim_q),
    .comment_delim_i (comment_delim_q),
    .state_o         (state_d),
    .token_o         (tok_d)
  );

  // Commit parser state only for the word that moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode    <= csvt_pkg::ModeLineBegin;
      state_q.cnt     <= '0;
      state_q.prev_cr <= 1'b0;
      state_q.err     <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_tok_q <= tok_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_tok_q.field_index, out_tok_q.data_byte};
  assign m_axis_tuser_o  = {out_tok_q.parse_error, out_tok_q.field_end, out_tok_q.data_valid};
  assign m_axis_tlast_o  = out_tok_q.record_end;

endmodule

>>> hdl/csvt_checker.sv
// Port-level checker for the CSV field tokenizer and its bind to the top level.
// Depends on csv_field_tokenizer_unit.
module csvt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // stalled token holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))
    else $error("token changed while stalled");

  // a content byte never comes with a field or record end
  a_data_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> !m_axis_tuser_o[1] && !m_axis_tlast_o)
    else $error("content byte together with a field or record end");

  // no content byte means a zero data byte
  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o[7:0] == 8'd0)
    else $error("data byte nonzero without data valid");

  // parse error is sticky
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tuser_o[2] |=>
      !m_axis_tvalid_o || m_axis_tuser_o[2])
    else $error("parse error cleared");

endmodule

bind csv_field_tokenizer_unit csvt_checker u_csvt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
